>>> hw/rtl/cadr_pkg.sv
// shared types, widths and constants of the calibrated adc to resistance core
package cadr_pkg;

    // default number of sensor channels
    localparam int CHANNELS_DEFAULT = 24;

    // opcodes
    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    // field and datapath widths
    localparam int CHAN_W = 5;
    localparam int CODE_W = 12;
    localparam int RES_W  = 16;
    localparam int OFF_W  = 17;   // signed offset, 1/16 count
    localparam int M16_W  = 18;   // signed corrected code, 1/16 count
    localparam int DENS_W = 30;   // signed denominator
    localparam int DEN_W  = 28;   // positive divisor
    localparam int NUM_W  = 44;   // positive dividend
    localparam int Q_W    = 33;   // quotient bits that can be nonzero
    localparam int T_W    = 19;   // biased quotient below the high clamp
    localparam int RCP_W  = 20;   // reciprocal of five
    localparam int RCP_SH = 22;
    localparam int PROD_W = T_W + RCP_W;

    // fixed point constants
    localparam logic [OFF_W-1:0]         REF16     = 17'd1401;
    localparam logic signed [DENS_W-1:0] DEN_BASE  = 30'sd235929600;
    localparam logic signed [DENS_W-1:0] DEN_SLOPE = 30'sd3300;
    localparam logic [DEN_W-1:0]         SCALE_NUM = 28'd165000000;
    localparam logic [Q_W-1:0]           Q_LOW     = 33'd501;
    localparam logic [Q_W-1:0]           Q_HIGH    = 33'd325506;
    localparam logic [RES_W-1:0]         RES_MAX   = 16'd65000;
    localparam logic [RCP_W-1:0]         RECIP5    = 20'd838861;

    // input transaction
    typedef struct packed {
        logic              opcode;
        logic [CHAN_W-1:0] channel;
        logic [CODE_W-1:0] sample;
    } cadr_in_t;

    // result transaction
    typedef struct packed {
        logic [RES_W-1:0] resistance;
        logic             clamped_high;
        logic             clamped_low;
        logic             used_calibration;
    } cadr_out_t;

    // offset table request
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [CHAN_W-1:0] channel;
        logic [OFF_W-1:0]  wr_data;
    } cadr_tbl_req_t;

    // offset table read response
    typedef struct packed {
        logic             use_cal;
        logic [OFF_W-1:0] offset;
    } cadr_tbl_rd_t;

endpackage

>>> hw/rtl/cadr_table.sv
// per-channel offset memory with entry valid bits and calibrated flag
module cadr_table
    import cadr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cadr_tbl_req_t req,
    output cadr_tbl_rd_t  rd
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [OFF_W-1:0]    mem [CHANNELS];
    logic [CHANNELS-1:0] entry_valid_reg;
    logic                table_valid_reg;
    logic [OFF_W-1:0]    rd_data_reg;
    logic                rd_entry_reg;
    logic                rd_use_reg;
    logic                in_range;
    logic [IDX_W-1:0]    idx;

    assign in_range = 32'(req.channel) < CHANNELS;
    assign idx      = in_range ? IDX_W'(req.channel) : '0;

    // offset storage, no reset
    always_ff @(posedge aclk) begin
        if (req.wr_en && in_range) begin
            mem[idx] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[idx];
        end
    end

    // valid bits and registered read flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            table_valid_reg <= 1'b0;
            rd_entry_reg    <= 1'b0;
            rd_use_reg      <= 1'b0;
        end else begin
            if (req.wr_en && in_range) begin
                entry_valid_reg[idx] <= 1'b1;
                table_valid_reg      <= 1'b1;
            end
            if (req.rd_en) begin
                rd_entry_reg <= in_range && entry_valid_reg[idx];
                rd_use_reg   <= in_range && table_valid_reg;
            end
        end
    end

    // an entry never written reads as zero
    assign rd.use_cal = rd_use_reg;
    assign rd.offset  = rd_entry_reg ? rd_data_reg : '0;

endmodule

>>> hw/rtl/cadr_div.sv
// restoring divider, one quotient bit per cycle
module cadr_div
    import cadr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   work_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_step;
    logic             busy;

    // one trial subtract
    always_comb begin
        trial    = {rem_reg, work_reg[Q_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_step = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    assign busy = cnt_reg != '0;
    assign done = cnt_reg == CNT_W'(1);
    assign quot = work_reg;

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(Q_W);
        end else if (busy) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // upper dividend bits preload the remainder, the quotient is known to fit Q_W bits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= DEN_W'(num[NUM_W-1:Q_W]);
            work_reg <= num[Q_W-1:0];
            den_reg  <= den;
        end else if (busy) begin
            rem_reg  <= rem_step;
            work_reg <= {work_reg[Q_W-2:0], ge};
        end
    end

endmodule

>>> hw/rtl/calibrated_adc_to_resistance_core.sv
// top level: sequencer, offset table and shared divider of the adc to resistance core
//
//   channel   ports                       direction   payload
//   input     s_valid s_ready s_payload   in          cadr_in_t
//   result    m_valid m_ready m_payload   out         cadr_out_t
//
// a measure transaction runs from acceptance through m16, den, num, the 33 steps of
// the one-bit-per-cycle divider, res, scale and done; num goes to done when the code
// is not positive, res when the quotient clamps; a calibrate goes straight to done.
// one transaction at a time: s_ready is high only while the sequencer is idle.
// reset clears the sequencer, the calibrated flag and every entry valid bit at once.
// a result held by m_ready low stalls the sequencer until the output register frees.
module calibrated_adc_to_resistance_core
    import cadr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cadr_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output cadr_out_t m_payload
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_M16   = 3'd1;
    localparam logic [2:0] S_DEN   = 3'd2;
    localparam logic [2:0] S_NUM   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;
    localparam logic [2:0] S_SCALE = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    cadr_in_t                  in_reg;
    logic signed [M16_W-1:0]   m16_reg;
    logic signed [DENS_W-1:0]  den_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [RES_W-1:0]          res_reg;
    logic                      hi_reg;
    logic                      lo_reg;
    logic                      used_reg;
    logic                      m_valid_reg;
    cadr_out_t                 m_payload_reg;

    cadr_tbl_req_t             tbl_req;
    cadr_tbl_rd_t              tbl_rd;
    logic                      accept;
    logic                      out_free;
    logic signed [M16_W-1:0]   code16;
    logic signed [M16_W-1:0]   off_ext;
    logic signed [M16_W-1:0]   m16_next;
    logic signed [DENS_W-1:0]  den_next;
    logic [NUM_W-1:0]          num_next;
    logic [T_W-1:0]            t_val;
    logic [PROD_W-1:0]         prod_next;
    logic                      div_start;
    logic                      div_done;
    logic [Q_W-1:0]            div_quot;

    assign s_ready  = state_reg == S_IDLE;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // offset table access at acceptance
    assign tbl_req.rd_en   = accept && (s_payload.opcode == OP_MEASURE);
    assign tbl_req.wr_en   = accept && (s_payload.opcode == OP_CALIBRATE);
    assign tbl_req.channel = s_payload.channel;
    assign tbl_req.wr_data = REF16 - {1'b0, s_payload.sample, 4'b0000};

    cadr_table #(
        .CHANNELS(CHANNELS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rd      (tbl_rd)
    );

    // corrected code, denominator and dividend
    always_comb begin
        code16    = $signed({2'b00, in_reg.sample, 4'b0000});
        off_ext   = tbl_rd.use_cal ? M16_W'($signed(tbl_rd.offset)) : '0;
        m16_next  = code16 + off_ext;
        den_next  = DEN_BASE - DEN_SLOPE * DENS_W'(m16_reg);
        num_next  = NUM_W'(SCALE_NUM) * NUM_W'(m16_reg[OFF_W-1:0]);
        t_val     = T_W'(div_quot - Q_LOW);
        prod_next = PROD_W'(t_val) * PROD_W'(RECIP5);
    end

    assign div_start = (state_reg == S_NUM) && (m16_reg > 0) && (den_reg > 0);

    cadr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_next),
        .den     (den_reg[DEN_W-1:0]),
        .done    (div_done),
        .quot    (div_quot)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_payload.opcode == OP_CALIBRATE) ? S_DONE : S_M16;
                end
            end
            S_M16:   state_next = S_DEN;
            S_DEN:   state_next = S_NUM;
            S_NUM:   state_next = div_start ? S_DIV : S_DONE;
            S_DIV: begin
                if (div_done) begin
                    state_next = S_RES;
                end
            end
            S_RES: begin
                if (div_quot < Q_LOW || div_quot >= Q_HIGH) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    in_reg   <= s_payload;
                    res_reg  <= '0;
                    hi_reg   <= 1'b0;
                    lo_reg   <= 1'b0;
                    used_reg <= 1'b0;
                end
            end
            S_M16: begin
                m16_reg  <= m16_next;
                used_reg <= tbl_rd.use_cal;
            end
            S_DEN: begin
                den_reg <= den_next;
            end
            S_NUM: begin
                // non-positive code or negative denominator gives a low clamp
                if (m16_reg <= 0 || den_reg < 0) begin
                    lo_reg <= 1'b1;
                end else if (den_reg == '0) begin
                    res_reg <= RES_MAX;
                    hi_reg  <= 1'b1;
                end
            end
            S_RES: begin
                if (div_quot < Q_LOW) begin
                    lo_reg <= 1'b1;
                end else if (div_quot >= Q_HIGH) begin
                    res_reg <= RES_MAX;
                    hi_reg  <= 1'b1;
                end else begin
                    prod_reg <= prod_next;
                end
            end
            S_SCALE: begin
                // floor of the biased quotient over five
                res_reg <= prod_reg[RCP_SH +: RES_W];
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_payload_reg.resistance       <= res_reg;
            m_payload_reg.clamped_high     <= hi_reg;
            m_payload_reg.clamped_low      <= lo_reg;
            m_payload_reg.used_calibration <= used_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // checks
    a_clamp_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_payload.clamped_high && m_payload.clamped_low))
        else $error("both clamp flags set");

    a_clamp_hi_val: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.clamped_high |-> m_payload.resistance == RES_MAX)
        else $error("high clamp without full scale value");

    a_clamp_lo_val: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.clamped_low |-> m_payload.resistance == '0)
        else $error("low clamp without zero value");

    a_div_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside its phase");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("ready right after an accepted transaction");

endmodule
